FILE: src/btpc_pkg.sv
// Shared types and constants for the barometer temperature/pressure compensation.
// Used by every module of the block; depends on nothing else.
package btpc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_TEMP    = 3'd0,
    CFG_PRES_LO = 3'd1,
    CFG_PRES_HI = 3'd2,
    CFG_PRES_P9 = 3'd3
  } cfg_index_t;

  // Saturation limits
  localparam logic signed [24:0] FineMin = -25'sd524288;
  localparam logic signed [24:0] FineMax = 25'sd524287;
  localparam logic signed [15:0] CentMin = -16'sd4000;
  localparam logic signed [15:0] CentMax = 16'sd8500;
  localparam logic signed [63:0] PresMin = 64'sd7680000;
  localparam logic signed [63:0] PresMax = 64'sd28160000;

  // Calibration words as decoded from the configuration registers
  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } coeff_t;

  // Side data that rides along with the division
  typedef struct packed {
    logic signed [19:0] fine;
    logic signed [14:0] cent;
    logic               neg;
    logic               nz;
  } side_t;

endpackage

FILE: src/btpc_sample_if.sv
// Request channel carrying one raw temperature/pressure pair.
// Standalone interface; no package dependency.
interface btpc_sample_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;

  modport source(output valid, raw_temperature, raw_pressure, input ready);
  modport sink(input valid, raw_temperature, raw_pressure, output ready);
endinterface

FILE: src/btpc_result_if.sv
// Result channel carrying compensated temperature and pressure.
// Standalone interface; no package dependency.
interface btpc_result_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] fine_temperature;
  logic signed [14:0] temperature_centi;
  logic        [24:0] pressure_q24_8;
  logic               pressure_valid;

  modport source(output valid, fine_temperature, temperature_centi, pressure_q24_8,
                 pressure_valid, input ready);
  modport sink(input valid, fine_temperature, temperature_centi, pressure_q24_8,
               pressure_valid, output ready);
endinterface

FILE: src/btpc_temp.sv
// Temperature front end: five stages from raw temperature to fine and centi values.
// Depends on btpc_pkg (coeff_t, saturation limits).
module btpc_temp (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic        [19:0] raw_temperature,
  input  logic        [19:0] raw_pressure,
  input  btpc_pkg::coeff_t   coeff,
  output logic               out_valid,
  output logic signed [19:0] fine,
  output logic signed [14:0] cent,
  output logic signed [20:0] x,
  output logic        [19:0] adc_p
);

  logic [4:0] v;

  logic signed [18:0] a_diff;
  logic signed [16:0] a_base;
  logic        [19:0] a_p;
  logic signed [34:0] b_m1;
  logic signed [33:0] b_sq;
  logic        [19:0] b_p;
  logic signed [23:0] c_s1;
  logic signed [37:0] c_m2;
  logic        [19:0] c_p;
  logic signed [19:0] d_fine;
  logic        [19:0] d_p;

  logic signed [18:0] diff_c;
  logic signed [16:0] base_c;
  logic signed [24:0] sum_c;
  logic signed [19:0] fine_c;
  logic signed [23:0] f5_c;
  logic signed [15:0] ct_c;
  logic signed [14:0] cent_c;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[3:0], in_valid};
    end
  end
  assign out_valid = v[4];

  // Offsets from T1
  always_comb begin
    diff_c = $signed({2'b00, raw_temperature[19:3]}) - $signed({2'b00, coeff.t1, 1'b0});
    base_c = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, coeff.t1});
  end

  // Sum the two terms and saturate
  always_comb begin
    sum_c = c_s1 + $signed(c_m2[37:14]);
    if (sum_c < btpc_pkg::FineMin) begin
      fine_c = btpc_pkg::FineMin[19:0];
    end else if (sum_c > btpc_pkg::FineMax) begin
      fine_c = btpc_pkg::FineMax[19:0];
    end else begin
      fine_c = sum_c[19:0];
    end
  end

  // Scale to 0.01 degC and saturate
  always_comb begin
    f5_c = d_fine * 24'sd5 + 24'sd128;
    ct_c = $signed(f5_c[23:8]);
    if (ct_c < btpc_pkg::CentMin) begin
      cent_c = btpc_pkg::CentMin[14:0];
    end else if (ct_c > btpc_pkg::CentMax) begin
      cent_c = btpc_pkg::CentMax[14:0];
    end else begin
      cent_c = ct_c[14:0];
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (adv) begin
      a_diff <= diff_c;
      a_base <= base_c;
      a_p    <= raw_pressure;
      b_m1   <= a_diff * coeff.t2;
      b_sq   <= a_base * a_base;
      b_p    <= a_p;
      c_s1   <= $signed(b_m1[34:11]);
      c_m2   <= $signed(b_sq[33:12]) * coeff.t3;
      c_p    <= b_p;
      d_fine <= fine_c;
      d_p    <= c_p;
      fine   <= d_fine;
      cent   <= cent_c;
      x      <= d_fine - 21'sd128000;
      adc_p  <= d_p;
    end
  end

endmodule

FILE: src/btpc_poly.sv
// Pressure polynomial: six stages producing dividend and divisor magnitudes.
// Depends on btpc_pkg (coeff_t, side_t).
module btpc_poly (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic signed [19:0] fine,
  input  logic signed [14:0] cent,
  input  logic signed [20:0] x,
  input  logic        [19:0] adc_p,
  input  btpc_pkg::coeff_t   coeff,
  output logic               out_valid,
  output logic        [63:0] num,
  output logic        [30:0] den,
  output btpc_pkg::side_t    side
);

  logic [5:0] v;

  // Carried temperature results, one slot per stage
  logic signed [19:0] fine_d [5];
  logic signed [14:0] cent_d [5];

  logic signed [41:0] s1_xx;
  logic signed [36:0] s1_xp5;
  logic signed [36:0] s1_xp2;
  logic        [19:0] s1_p;
  logic signed [56:0] s2_xxp6;
  logic signed [56:0] s2_xxp3;
  logic signed [36:0] s2_xp5;
  logic signed [36:0] s2_xp2;
  logic        [19:0] s2_p;
  logic signed [59:0] s3_s2;
  logic signed [51:0] s3_v;
  logic        [19:0] s3_p;
  logic signed [30:0] s4_den;
  logic signed [60:0] s4_num;
  logic signed [30:0] s5_den;
  logic        [63:0] s5_num;

  logic signed [68:0] prod_c;
  logic        [20:0] pd_c;
  logic signed [73:0] scaled_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[4:0], in_valid};
    end
  end
  assign out_valid = v[5];

  // Divisor product wraps at 64 bits; pressure offset from full scale
  always_comb begin
    prod_c   = s3_v * $signed({1'b0, coeff.p1});
    pd_c     = 21'd1048576 - {1'b0, s3_p};
    scaled_c = s4_num * $signed(13'd3125);
  end

  // Carry temperature results
  always_ff @(posedge clk) begin
    if (adv) begin
      fine_d[0] <= fine;
      cent_d[0] <= cent;
      for (int i = 1; i < 5; i++) begin
        fine_d[i] <= fine_d[i-1];
        cent_d[i] <= cent_d[i-1];
      end
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_xx   <= x * x;
      s1_xp5  <= x * coeff.p5;
      s1_xp2  <= x * coeff.p2;
      s1_p    <= adc_p;
      s2_xxp6 <= $signed(s1_xx[40:0]) * coeff.p6;
      s2_xxp3 <= $signed(s1_xx[40:0]) * coeff.p3;
      s2_xp5  <= s1_xp5;
      s2_xp2  <= s1_xp2;
      s2_p    <= s1_p;
      s3_s2   <= s2_xxp6 + $signed({s2_xp5, 17'b0}) + $signed({coeff.p4, 35'b0});
      s3_v    <= $signed(s2_xxp3[56:8]) + $signed({s2_xp2, 12'b0}) + (52'sd1 <<< 47);
      s3_p    <= s2_p;
      s4_den  <= $signed(prod_c[63:33]);
      s4_num  <= $signed({1'b0, pd_c, 31'b0}) - s3_s2;
      s5_den  <= s4_den;
      s5_num  <= scaled_c[63:0];
      // Split into magnitudes and a result sign
      num       <= s5_num[63] ? (~s5_num + 64'd1) : s5_num;
      den       <= s5_den[30] ? (~s5_den + 31'd1) : s5_den;
      side.fine <= fine_d[4];
      side.cent <= cent_d[4];
      side.neg  <= s5_num[63] ^ s5_den[30];
      side.nz   <= |s5_den;
    end
  end

endmodule

FILE: src/btpc_div.sv
// Pipelined restoring divider: 64 stages, one quotient bit per stage.
// Depends on btpc_pkg (side_t).
module btpc_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [63:0]     num,
  input  logic [30:0]     den,
  input  btpc_pkg::side_t in_side,
  output logic            out_valid,
  output logic [63:0]     quot,
  output btpc_pkg::side_t out_side
);

  logic [63:0]     v;
  logic [30:0]     rem [64];
  logic [63:0]     dq  [64];
  logic [30:0]     dv  [64];
  btpc_pkg::side_t sd  [64];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[62:0], in_valid};
    end
  end

  for (genvar i = 0; i < 64; i++) begin : g_stage
    logic [30:0]     rp;
    logic [63:0]     qp;
    logic [30:0]     dp;
    btpc_pkg::side_t sp;
    logic [32:0]     diff;

    if (i == 0) begin : g_first
      assign rp = '0;
      assign qp = num;
      assign dp = den;
      assign sp = in_side;
    end else begin : g_rest
      assign rp = rem[i-1];
      assign qp = dq[i-1];
      assign dp = dv[i-1];
      assign sp = sd[i-1];
    end

    // Trial subtract of the divisor from the shifted remainder
    assign diff = {1'b0, rp, qp[63]} - {2'b00, dp};

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[i] <= diff[32] ? {rp[29:0], qp[63]} : diff[30:0];
        dq[i]  <= {qp[62:0], ~diff[32]};
        dv[i]  <= dp;
        sd[i]  <= sp;
      end
    end
  end

  assign out_valid = v[63];
  assign quot      = dq[63];
  assign out_side  = sd[63];

endmodule

FILE: src/btpc_post.sv
// Post-division terms (P7..P9), final scaling and saturation; last stage is the output register.
// Depends on btpc_pkg (coeff_t, side_t, pressure limits).
module btpc_post (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic        [63:0] quot,
  input  btpc_pkg::side_t    side,
  input  btpc_pkg::coeff_t   coeff,
  output logic               out_valid,
  output logic signed [19:0] fine,
  output logic signed [14:0] cent,
  output logic        [24:0] pres,
  output logic               pvalid
);

  logic [7:0] v;

  btpc_pkg::side_t sd [7];

  logic [63:0]        q1_p;
  logic [63:0]        q2_p;
  logic [50:0]        q2_h;
  logic signed [48:0] q2_m9l;
  logic signed [34:0] q2_m9h;
  logic signed [48:0] q2_m8l;
  logic signed [47:0] q2_m8h;
  logic [63:0]        q3_p;
  logic [50:0]        q3_h;
  logic [63:0]        q3_g;
  logic [63:0]        q3_b8;
  logic [63:0]        q4_p;
  logic [63:0]        q4_ll;
  logic [31:0]        q4_c1;
  logic [31:0]        q4_c2;
  logic [63:0]        q4_bt;
  logic [63:0]        q5_p;
  logic [63:0]        q5_gh;
  logic [63:0]        q5_bt;
  logic [63:0]        q6_s;
  logic [63:0]        q7_r;

  logic [63:0] hs_c;
  logic [24:0] pres_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[6:0], in_valid};
    end
  end
  assign out_valid = v[7];

  // Sign-extended p >>> 13 for the wrapped product
  assign hs_c = {{13{q3_h[50]}}, q3_h};

  // Saturate a valid pressure; zero when the divisor was zero
  always_comb begin
    if ($signed(q7_r) < btpc_pkg::PresMin) begin
      pres_c = btpc_pkg::PresMin[24:0];
    end else if ($signed(q7_r) > btpc_pkg::PresMax) begin
      pres_c = btpc_pkg::PresMax[24:0];
    end else begin
      pres_c = q7_r[24:0];
    end
    if (!sd[6].nz) begin
      pres_c = '0;
    end
  end

  // Carry side data
  always_ff @(posedge clk) begin
    if (adv) begin
      sd[0] <= side;
      for (int i = 1; i < 7; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (adv) begin
      // Apply the result sign
      q1_p   <= side.neg ? (~quot + 64'd1) : quot;
      // Partial products of P9 * h and P8 * p
      q2_p   <= q1_p;
      q2_h   <= q1_p[63:13];
      q2_m9l <= coeff.p9 * $signed({1'b0, q1_p[44:13]});
      q2_m9h <= coeff.p9 * $signed(q1_p[63:45]);
      q2_m8l <= coeff.p8 * $signed({1'b0, q1_p[31:0]});
      q2_m8h <= coeff.p8 * $signed(q1_p[63:32]);
      // Combine partials modulo 2^64
      q3_p   <= q2_p;
      q3_h   <= q2_h;
      q3_g   <= {{15{q2_m9l[48]}}, q2_m9l} + {q2_m9h[31:0], 32'b0};
      q3_b8  <= {{15{q2_m8l[48]}}, q2_m8l} + {q2_m8h[31:0], 32'b0};
      // Low 64 bits of g * h from 32-bit pieces
      q4_p   <= q3_p;
      q4_ll  <= q3_g[31:0] * hs_c[31:0];
      q4_c1  <= 32'(q3_g[31:0] * hs_c[63:32]);
      q4_c2  <= 32'(q3_g[63:32] * hs_c[31:0]);
      q4_bt  <= {{19{q3_b8[63]}}, q3_b8[63:19]};
      q5_p   <= q4_p;
      q5_gh  <= q4_ll + {q4_c1 + q4_c2, 32'b0};
      q5_bt  <= q4_bt;
      q6_s   <= q5_p + {{25{q5_gh[63]}}, q5_gh[63:25]} + q5_bt;
      q7_r   <= {{8{q6_s[63]}}, q6_s[63:8]} + {{44{coeff.p7[15]}}, coeff.p7, 4'b0};
      // Output register
      fine   <= sd[6].fine;
      cent   <= sd[6].cent;
      pres   <= pres_c;
      pvalid <= sd[6].nz;
    end
  end

endmodule

FILE: src/barometer_temp_pressure_compensation.sv
// Barometer temperature/pressure compensation, fully pipelined.
// A request passes 5 temperature, 6 polynomial, 64 divider and 8 post
// stages on its way to the result; throughput one request per cycle when not stalled.
// The whole pipeline stalls only while a result waits on the output.
// Synchronous reset clears valid bits and all calibration registers to zero.
// Depends on btpc_pkg, btpc_sample_if, btpc_result_if and the btpc_* stages.
module barometer_temp_pressure_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  btpc_sample_if.sink   sample,
  btpc_result_if.source result
);

  logic [47:0] temp_coeffs;
  logic [63:0] pres_lo;
  logic [63:0] pres_hi;
  logic [15:0] pres_p9;

  btpc_pkg::coeff_t coeff;
  logic             adv;

  logic               t_valid;
  logic signed [19:0] t_fine;
  logic signed [14:0] t_cent;
  logic signed [20:0] t_x;
  logic        [19:0] t_p;

  logic            p_valid;
  logic [63:0]     p_num;
  logic [30:0]     p_den;
  btpc_pkg::side_t p_side;

  logic            d_valid;
  logic [63:0]     d_quot;
  btpc_pkg::side_t d_side;

  // Calibration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs <= '0;
      pres_lo     <= '0;
      pres_hi     <= '0;
      pres_p9     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        btpc_pkg::CFG_TEMP:    temp_coeffs <= cfg_data[47:0];
        btpc_pkg::CFG_PRES_LO: pres_lo     <= cfg_data;
        btpc_pkg::CFG_PRES_HI: pres_hi     <= cfg_data;
        btpc_pkg::CFG_PRES_P9: pres_p9     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Decode calibration words
  always_comb begin
    coeff.t1 = temp_coeffs[15:0];
    coeff.t2 = $signed(temp_coeffs[31:16]);
    coeff.t3 = $signed(temp_coeffs[47:32]);
    coeff.p1 = pres_lo[15:0];
    coeff.p2 = $signed(pres_lo[31:16]);
    coeff.p3 = $signed(pres_lo[47:32]);
    coeff.p4 = $signed(pres_lo[63:48]);
    coeff.p5 = $signed(pres_hi[15:0]);
    coeff.p6 = $signed(pres_hi[31:16]);
    coeff.p7 = $signed(pres_hi[47:32]);
    coeff.p8 = $signed(pres_hi[63:48]);
    coeff.p9 = $signed(pres_p9);
  end

  // Advance the pipeline unless a result is held
  assign adv          = !result.valid || result.ready;
  assign sample.ready = adv;

  btpc_temp u_temp (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .in_valid        (sample.valid),
    .raw_temperature (sample.raw_temperature),
    .raw_pressure    (sample.raw_pressure),
    .coeff           (coeff),
    .out_valid       (t_valid),
    .fine            (t_fine),
    .cent            (t_cent),
    .x               (t_x),
    .adc_p           (t_p)
  );

  btpc_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (t_valid),
    .fine      (t_fine),
    .cent      (t_cent),
    .x         (t_x),
    .adc_p     (t_p),
    .coeff     (coeff),
    .out_valid (p_valid),
    .num       (p_num),
    .den       (p_den),
    .side      (p_side)
  );

  btpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (p_valid),
    .num       (p_num),
    .den       (p_den),
    .in_side   (p_side),
    .out_valid (d_valid),
    .quot      (d_quot),
    .out_side  (d_side)
  );

  btpc_post u_post (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (d_valid),
    .quot      (d_quot),
    .side      (d_side),
    .coeff     (coeff),
    .out_valid (result.valid),
    .fine      (result.fine_temperature),
    .cent      (result.temperature_centi),
    .pres      (result.pressure_q24_8),
    .pvalid    (result.pressure_valid)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for barometer_temp_pressure_compensation.
// Drives raw reading pairs through the request channel and checks every result
// against a 64-bit fixed-point compensation predictor; needs btpc_pkg and the two interfaces.
`timescale 1ns / 100ps

module testbench;

  localparam logic [2:0] CfgUnused = 3'd5;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 120;
  localparam int RandomItems = 850;

  typedef struct {
    logic signed [19:0] fine;
    logic signed [14:0] cent;
    logic        [24:0] pres;
    logic               pvalid;
  } comp_t;

  typedef struct {
    int          phase;
    logic [19:0] raw_t;
    logic [19:0] raw_p;
    bit          typed;
    comp_t       res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = btpc_pkg::CFG_TEMP;
  logic [63:0] cfg_data = '0;

  btpc_sample_if sample_ch();
  btpc_result_if result_ch();

  barometer_temp_pressure_compensation uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample(sample_ch.sink), .result(result_ch.source)
  );

  // Calibration copy held by the predictor
  logic [47:0] cal_temp;
  logic [63:0] cal_plo;
  logic [63:0] cal_phi;
  logic [15:0] cal_p9;

  comp_t pending_results[$];
  int    errors = 0;
  int    cycles = 0;
  int    send_idle = 0;
  int    recv_idle = 0;
  int    hold_cnt = 0;
  bit    hold_req = 0;
  bit    hold_done = 0;

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.raw_temperature = '0;
    sample_ch.raw_pressure = '0;
    result_ch.ready = 1'b0;
  end

  // Clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint sx16(logic [15:0] v);
    return longint'({{48{v[15]}}, v});
  endfunction

  function automatic longint sat(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Compensate one reading pair with the current calibration
  function automatic comp_t compensate(logic [19:0] raw_t, logic [19:0] raw_p);
    longint adc_t, adc_p, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint a, b, x, s1, s2, p, num, fine, cent, pres;
    comp_t r;
    adc_t = longint'({44'b0, raw_t});
    adc_p = longint'({44'b0, raw_p});
    t1 = longint'({48'b0, cal_temp[15:0]});
    t2 = sx16(cal_temp[31:16]);
    t3 = sx16(cal_temp[47:32]);
    p1 = longint'({48'b0, cal_plo[15:0]});
    p2 = sx16(cal_plo[31:16]);
    p3 = sx16(cal_plo[47:32]);
    p4 = sx16(cal_plo[63:48]);
    p5 = sx16(cal_phi[15:0]);
    p6 = sx16(cal_phi[31:16]);
    p7 = sx16(cal_phi[47:32]);
    p8 = sx16(cal_phi[63:48]);
    p9 = sx16(cal_p9);
    pres = 0;
    r.pvalid = 1'b0;
    // temperature
    a = (adc_t >>> 3) - (t1 <<< 1);
    s1 = (a * t2) >>> 11;
    b = (adc_t >>> 4) - t1;
    s2 = (((b * b) >>> 12) * t3) >>> 14;
    fine = sat(s1 + s2, -524288, 524287);
    cent = sat((fine * 5 + 128) >>> 8, -4000, 8500);
    // pressure
    x = fine - 128000;
    s2 = x * x * p6;
    s2 = s2 + ((x * p5) <<< 17);
    s2 = s2 + (p4 <<< 35);
    s1 = ((x * x * p3) >>> 8) + ((x * p2) <<< 12);
    s1 = (((64'sd1 <<< 47) + s1) * p1) >>> 33;
    if (s1 != 0) begin
      p = 1048576 - adc_p;
      num = ((p <<< 31) - s2) * 3125;
      // avoid the one overflowing quotient
      p = (s1 == -1) ? -num : num / s1;
      a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
      b = (p8 * p) >>> 19;
      p = ((p + a + b) >>> 8) + (p7 <<< 4);
      pres = sat(p, 7680000, 28160000);
      r.pvalid = 1'b1;
    end
    r.fine = fine[19:0];
    r.cent = cent[14:0];
    r.pres = pres[24:0];
    return r;
  endfunction

  // Write one calibration register and mirror it
  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      btpc_pkg::CFG_TEMP:    cal_temp = data[47:0];
      btpc_pkg::CFG_PRES_LO: cal_plo = data;
      btpc_pkg::CFG_PRES_HI: cal_phi = data;
      btpc_pkg::CFG_PRES_P9: cal_p9 = data[15:0];
      default: ;
    endcase
  endtask

  // Wait for the pipeline to drain, then load a full calibration set
  task automatic load_calibration(logic [63:0] rt, logic [63:0] rlo, logic [63:0] rhi,
                                  logic [63:0] r9);
    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    write_reg(btpc_pkg::CFG_TEMP, rt);
    write_reg(btpc_pkg::CFG_PRES_LO, rlo);
    write_reg(btpc_pkg::CFG_PRES_HI, rhi);
    write_reg(btpc_pkg::CFG_PRES_P9, r9);
    write_reg(CfgUnused, {$urandom, $urandom});
  endtask

  // Offer one request and record its expected result on acceptance
  task automatic send_pair(logic [19:0] rt, logic [19:0] rp, bit typed, comp_t res);
    while ($urandom_range(99) < send_idle) begin
      sample_ch.valid = 1'b0;
      @(negedge clk);
    end
    sample_ch.valid = 1'b1;
    sample_ch.raw_temperature = rt;
    sample_ch.raw_pressure = rp;
    do @(posedge clk); while (!sample_ch.ready);
    pending_results.push_back(typed ? res : compensate(rt, rp));
    @(negedge clk);
    sample_ch.valid = 1'b0;
  endtask

  // Receiver: random ready, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_cnt = 600;
      hold_done = 1;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      result_ch.ready = 1'b0;
    end else begin
      result_ch.ready = ($urandom_range(99) >= recv_idle);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    comp_t exp_r;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no pending request");
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_ch.fine_temperature !== exp_r.fine) begin
          $error("fine_temperature expected %0d actual %0d", exp_r.fine,
                 result_ch.fine_temperature);
          errors++;
        end
        if (result_ch.temperature_centi !== exp_r.cent) begin
          $error("temperature_centi expected %0d actual %0d", exp_r.cent,
                 result_ch.temperature_centi);
          errors++;
        end
        if (result_ch.pressure_q24_8 !== exp_r.pres) begin
          $error("pressure_q24_8 expected %0d actual %0d", exp_r.pres,
                 result_ch.pressure_q24_8);
          errors++;
        end
        if (result_ch.pressure_valid !== exp_r.pvalid) begin
          $error("pressure_valid expected %0d actual %0d", exp_r.pvalid,
                 result_ch.pressure_valid);
          errors++;
        end
      end
    end
  end

  function automatic row_t mk(int ph, logic [19:0] rt, logic [19:0] rp, bit typed,
                              int f, int c, int p, bit v);
    row_t r;
    r.phase = ph;
    r.raw_t = rt;
    r.raw_p = rp;
    r.typed = typed;
    r.res.fine = f[19:0];
    r.res.cent = c[14:0];
    r.res.pres = p[24:0];
    r.res.pvalid = v;
    return r;
  endfunction

  // Typical calibration set
  localparam logic [63:0] TypTemp = {16'h0000, 16'hFC18, 16'd26435, 16'd27504};
  localparam logic [63:0] TypPlo = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
  localparam logic [63:0] TypPhi = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};

  initial begin
    row_t  rows[$];
    comp_t none;
    int    cur_phase;
    int    seg;
    int    kind;
    logic [63:0] rt, rlo, rhi, r9;
    logic [19:0] at, ap;

    cal_temp = '0;
    cal_plo = '0;
    cal_phi = '0;
    cal_p9 = '0;
    none = '{default: '0};

    // Directed: zero calibration after reset, saturating temperature, typical set, all-ones set
    rows.push_back(mk(0, 20'd0, 20'd0, 1, 0, 0, 0, 0));
    rows.push_back(mk(0, 20'hFFFFF, 20'hFFFFF, 1, 0, 0, 0, 0));
    rows.push_back(mk(1, 20'hFFFFF, 20'd0, 1, 524287, 8500, 0, 0));
    rows.push_back(mk(1, 20'hFFFFF, 20'hFFFFF, 1, 524287, 8500, 0, 0));
    rows.push_back(mk(2, 20'hFFFFF, 20'd0, 1, -524288, -4000, 0, 0));
    rows.push_back(mk(2, 20'hFFFFF, 20'h55555, 1, -524288, -4000, 0, 0));
    rows.push_back(mk(3, 20'd0, 20'd0, 0, 0, 0, 0, 0));
    rows.push_back(mk(3, 20'hFFFFF, 20'hFFFFF, 0, 0, 0, 0, 0));
    rows.push_back(mk(3, 20'd519888, 20'd415148, 0, 0, 0, 0, 0));
    rows.push_back(mk(3, 20'd0, 20'hFFFFF, 0, 0, 0, 0, 0));
    rows.push_back(mk(3, 20'hFFFFF, 20'd0, 0, 0, 0, 0, 0));
    rows.push_back(mk(3, 20'hAAAAA, 20'h55555, 0, 0, 0, 0, 0));
    rows.push_back(mk(3, 20'd450000, 20'd300000, 0, 0, 0, 0, 0));
    rows.push_back(mk(4, 20'hFFFFF, 20'hFFFFF, 0, 0, 0, 0, 0));
    rows.push_back(mk(4, 20'd0, 20'd0, 0, 0, 0, 0, 0));
    rows.push_back(mk(4, 20'd519888, 20'd415148, 0, 0, 0, 0, 0));

    // Hold reset, then release it on a falling edge
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    cur_phase = 0;
    foreach (rows[i]) begin
      if (rows[i].phase != cur_phase) begin
        cur_phase = rows[i].phase;
        case (cur_phase)
          // high bits above each register width must be ignored
          1: load_calibration(64'hFFFF_0000_7FFF_0000, 0, 0, 0);
          2: load_calibration(64'h0000_0000_8000_0000, 0, 0, 0);
          3: load_calibration(TypTemp, TypPlo, TypPhi, 64'hABCD_0000_0000_1770);
          default: load_calibration('1, '1, '1, '1);
        endcase
      end
      send_pair(rows[i].raw_t, rows[i].raw_p, rows[i].typed, rows[i].res);
    end

    // Random part: nine calibration settings across three idling modes
    for (seg = 0; seg < 9; seg++) begin
      kind = (seg == 4) ? 0 : ((seg == 7) ? 1 : $urandom_range(2, 5));
      case (kind)
        0: begin rt = '0; rlo = '0; rhi = '0; r9 = '0; end
        1: begin rt = '1; rlo = '1; rhi = '1; r9 = 64'h7FFF; end
        2: begin
          rt = {$urandom, $urandom};
          rlo = {$urandom, $urandom};
          rhi = {$urandom, $urandom};
          r9 = {$urandom, $urandom};
        end
        default: begin
          rt = TypTemp ^ {16'h0000, 16'($urandom_range(255)), 16'($urandom_range(255)),
                          16'($urandom_range(4095))};
          rlo = TypPlo ^ {16'($urandom_range(255)), 16'($urandom_range(255)),
                          16'($urandom_range(1023)), 16'($urandom_range(4095))};
          rhi = TypPhi ^ {16'($urandom_range(255)), 16'($urandom_range(255)),
                          16'($urandom_range(3)), 16'($urandom_range(15))};
          r9 = 64'd6000 + 64'($urandom_range(511));
        end
      endcase
      load_calibration(rt, rlo, rhi, r9);
      if (seg < 3) begin send_idle = 22; recv_idle = 76; end
      else if (seg < 6) begin send_idle = 76; recv_idle = 22; end
      else begin send_idle = 0; recv_idle = 0; end
      if (seg == 6) hold_req = 1;
      repeat (RandomItems / 9) begin
        if ($urandom_range(99) < 70) begin
          at = 20'($urandom_range(600000, 400000));
          ap = 20'($urandom_range(450000, 250000));
        end else begin
          at = 20'($urandom);
          ap = 20'($urandom);
        end
        send_pair(at, ap, 0, none);
      end
    end

    // Drain and finish
    wait (pending_results.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/btpc_pkg.sv
src/btpc_sample_if.sv
src/btpc_result_if.sv
src/btpc_temp.sv
src/btpc_poly.sv
src/btpc_div.sv
src/btpc_post.sv
src/barometer_temp_pressure_compensation.sv
tb/testbench.sv
